// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SVA_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fexp_pkg.sv =====
// ----------------------------------------------------------------------------
// fexp_pkg
// Types, constants and the 2^(i/64) table for the float32 exp pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fexp_pkg;

  typedef struct packed {
    logic [31:0] x_bits;
    logic        is_last;
  } exp_in_t;

  typedef struct packed {
    logic [31:0] y_bits;
    logic        last_out;
  } exp_out_t;

  // register stages inside one fused multiply-add
  localparam int FMA_LAT = 5;

  localparam logic [31:0] MAGIC_BIAS  = 32'h4B40_0000;
  localparam logic [31:0] NEG_MAGIC   = 32'hCB40_0000;
  localparam logic [31:0] ZERO_CUTOFF = 32'hC2CF_F1B4;
  localparam logic [31:0] INF_CUTOFF  = 32'h42B1_7217;
  localparam logic [31:0] LOG2E_X64   = 32'h42B8_AA3B;
  localparam logic [31:0] NEG_LN2_HI  = 32'hBC31_7218;
  localparam logic [31:0] LN2_LO      = 32'h2E02_E308;
  localparam logic [31:0] COEF_C2     = 32'h3EFF_FF85;
  localparam logic [31:0] ONE_F       = 32'h3F80_0000;
  localparam logic [31:0] NEG_ZERO    = 32'h8000_0000;
  localparam logic [31:0] POS_INF     = 32'h7F80_0000;
  localparam logic [31:0] QNAN_F      = 32'h7FC0_0000;
  localparam logic [31:0] MIN_EXPO    = 32'hC100_0000;
  localparam logic [31:0] MAX_EXPO    = 32'h3F80_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

  localparam logic [31:0] POW2_FRAC [64] = '{
    32'h3F800000, 32'h3F8164D2, 32'h3F82CD87, 32'h3F843A29,
    32'h3F85AAC3, 32'h3F871F62, 32'h3F88980F, 32'h3F8A14D5,
    32'h3F8B95C2, 32'h3F8D1ADF, 32'h3F8EA43A, 32'h3F9031DC,
    32'h3F91C3D3, 32'h3F935A2B, 32'h3F94F4F0, 32'h3F96942D,
    32'h3F9837F0, 32'h3F99E046, 32'h3F9B8D3A, 32'h3F9D3EDA,
    32'h3F9EF532, 32'h3FA0B051, 32'h3FA27043, 32'h3FA43516,
    32'h3FA5FED7, 32'h3FA7CD94, 32'h3FA9A15B, 32'h3FAB7A3A,
    32'h3FAD583F, 32'h3FAF3B79, 32'h3FB123F6, 32'h3FB311C4,
    32'h3FB504F3, 32'h3FB6FD92, 32'h3FB8FBAF, 32'h3FBAFF5B,
    32'h3FBD08A4, 32'h3FBF179A, 32'h3FC12C4D, 32'h3FC346CD,
    32'h3FC5672A, 32'h3FC78D75, 32'h3FC9B9BE, 32'h3FCBEC15,
    32'h3FCE248C, 32'h3FD06334, 32'h3FD2A81E, 32'h3FD4F35B,
    32'h3FD744FD, 32'h3FD99D16, 32'h3FDBFBB8, 32'h3FDE60F5,
    32'h3FE0CCDF, 32'h3FE33F89, 32'h3FE5B907, 32'h3FE8396A,
    32'h3FEAC0C7, 32'h3FED4F30, 32'h3FEFE4BA, 32'h3FF28177,
    32'h3FF5257D, 32'h3FF7D0DF, 32'h3FFA83B3, 32'h3FFD3E0C
  };

endpackage

`default_nettype wire

// ===== rtl/fexp_fma.sv =====
// ----------------------------------------------------------------------------
// fexp_fma
// Pipelined binary32 fused multiply-add, a*b+c, single RNE rounding.
// Stages: unpack/normalize, multiply, align/add, normalize, round/pack.
// ----------------------------------------------------------------------------
`default_nettype none

module fexp_fma (
  input  logic        clk,
  input  logic        ce,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic [31:0] y
);

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc63(input logic [62:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 63; i++) begin
      if (v[i]) n = 6'(62 - i);
    end
    return n;
  endfunction

  function automatic logic [61:0] shr_st(input logic [61:0] v, input logic [12:0] d);
    logic [5:0]  sh;
    logic [61:0] mask;
    sh   = d[5:0];
    mask = (62'h1 << sh) - 62'h1;
    if (d >= 13'd63) begin
      return {61'd0, |v};
    end
    return (v >> sh) | {61'd0, |(v & mask)};
  endfunction

  // ---------------- stage 1: unpack, specials, normalize mantissas ----------
  logic        sa, sb, sc, sp;
  logic [7:0]  ea, eb, ec;
  logic [22:0] fa, fb, fc;
  logic [23:0] ma, mb, mc;
  logic        a_zero, b_zero, c_zero, any_nan;
  logic        spec;
  logic [31:0] spec_val;

  always_comb begin
    sa = a[31];
    sb = b[31];
    sc = c[31];
    sp = sa ^ sb;
    ea = a[30:23];
    eb = b[30:23];
    ec = c[30:23];
    fa = a[22:0];
    fb = b[22:0];
    fc = c[22:0];
    ma = {ea != 8'd0, fa};
    mb = {eb != 8'd0, fb};
    mc = {ec != 8'd0, fc};
    a_zero  = (ma == 24'd0);
    b_zero  = (mb == 24'd0);
    c_zero  = (mc == 24'd0);
    any_nan = (ea == 8'hFF && fa != 23'd0) || (eb == 8'hFF && fb != 23'd0) ||
              (ec == 8'hFF && fc != 23'd0);
  end

  always_comb begin
    spec     = 1'b1;
    spec_val = fexp_pkg::QNAN_F;
    priority if (any_nan) begin
      spec_val = fexp_pkg::QNAN_F;
    end else if (ea == 8'hFF || eb == 8'hFF) begin
      if (a_zero || b_zero) begin
        spec_val = fexp_pkg::QNAN_F;
      end else if (ec == 8'hFF && sc != sp) begin
        spec_val = fexp_pkg::QNAN_F;
      end else begin
        spec_val = {sp, fexp_pkg::POS_INF[30:0]};
      end
    end else if (ec == 8'hFF) begin
      spec_val = c;
    end else if ((a_zero || b_zero) && c_zero) begin
      spec_val = (sp && sc) ? fexp_pkg::NEG_ZERO : 32'd0;
    end else if (a_zero || b_zero) begin
      spec_val = c;
    end else begin
      spec = 1'b0;
    end
  end

  logic [4:0]         lza, lzb, lzc;
  logic signed [12:0] ea_n, eb_n, ec_n;

  always_comb begin
    lza  = lzc24(ma);
    lzb  = lzc24(mb);
    lzc  = lzc24(mc);
    ea_n = 13'((ea == 8'd0) ? 8'd1 : ea) - 13'(lza);
    eb_n = 13'((eb == 8'd0) ? 8'd1 : eb) - 13'(lzb);
    ec_n = 13'((ec == 8'd0) ? 8'd1 : ec) - 13'(lzc);
  end

  logic [23:0]        s1_ma_r, s1_mb_r, s1_mc_r;
  logic signed [12:0] s1_ea_r, s1_eb_r, s1_ec_r;
  logic               s1_sp_r, s1_sc_r, s1_cz_r, s1_spec_r;
  logic [31:0]        s1_sval_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_ma_r   <= ma << lza;
      s1_mb_r   <= mb << lzb;
      s1_mc_r   <= mc << lzc;
      s1_ea_r   <= ea_n;
      s1_eb_r   <= eb_n;
      s1_ec_r   <= ec_n;
      s1_sp_r   <= sp;
      s1_sc_r   <= sc;
      s1_cz_r   <= c_zero;
      s1_spec_r <= spec;
      s1_sval_r <= spec_val;
    end
  end

  // ---------------- stage 2: multiply -------------------------------------
  logic [47:0]        prod;
  logic [61:0]        mp62_nxt;
  logic signed [12:0] ep_nxt, ecx_nxt;

  always_comb begin
    prod     = 48'(s1_ma_r) * 48'(s1_mb_r);
    mp62_nxt = prod[47] ? {prod, 14'd0} : {prod[46:0], 15'd0};
    ep_nxt   = s1_ea_r + s1_eb_r - 13'sd300 - (prod[47] ? 13'sd14 : 13'sd15);
    ecx_nxt  = s1_ec_r - 13'sd188;
  end

  logic [61:0]        s2_mp_r, s2_mc_r;
  logic signed [12:0] s2_ep_r, s2_ecx_r;
  logic               s2_sp_r, s2_sc_r, s2_cz_r, s2_spec_r;
  logic [31:0]        s2_sval_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_mp_r   <= mp62_nxt;
      s2_mc_r   <= {s1_mc_r, 38'd0};
      s2_ep_r   <= ep_nxt;
      s2_ecx_r  <= ecx_nxt;
      s2_sp_r   <= s1_sp_r;
      s2_sc_r   <= s1_sc_r;
      s2_cz_r   <= s1_cz_r;
      s2_spec_r <= s1_spec_r;
      s2_sval_r <= s1_sval_r;
    end
  end

  // ---------------- stage 3: align and add --------------------------------
  logic [61:0]        mp_al, mc_al;
  logic signed [12:0] e_al;
  logic [62:0]        sum_nxt;
  logic               sgn_nxt;

  always_comb begin
    mp_al = s2_mp_r;
    mc_al = s2_mc_r;
    e_al  = s2_ep_r;
    if (s2_cz_r) begin
      mc_al = 62'd0;
    end else if (s2_ep_r >= s2_ecx_r) begin
      mc_al = shr_st(s2_mc_r, 13'(s2_ep_r - s2_ecx_r));
    end else begin
      mp_al = shr_st(s2_mp_r, 13'(s2_ecx_r - s2_ep_r));
      e_al  = s2_ecx_r;
    end
    if (s2_sp_r == s2_sc_r || s2_cz_r) begin
      sum_nxt = 63'(mp_al) + 63'(mc_al);
      sgn_nxt = s2_sp_r;
    end else if (mp_al >= mc_al) begin
      sum_nxt = 63'(mp_al - mc_al);
      sgn_nxt = s2_sp_r;
    end else begin
      sum_nxt = 63'(mc_al - mp_al);
      sgn_nxt = s2_sc_r;
    end
  end

  logic [62:0]        s3_sum_r;
  logic signed [12:0] s3_e_r;
  logic               s3_sgn_r, s3_spec_r;
  logic [31:0]        s3_sval_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_sum_r  <= sum_nxt;
      s3_e_r    <= e_al;
      s3_sgn_r  <= sgn_nxt;
      s3_spec_r <= s2_spec_r;
      s3_sval_r <= s2_sval_r;
    end
  end

  // ---------------- stage 4: normalize ------------------------------------
  logic [5:0] lzs;

  always_comb begin
    lzs = lzc63(s3_sum_r);
  end

  logic [62:0]        s4_m_r;
  logic signed [12:0] s4_be_r;
  logic               s4_sgn_r, s4_zero_r, s4_spec_r;
  logic [31:0]        s4_sval_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      s4_m_r    <= s3_sum_r << lzs;
      s4_be_r   <= s3_e_r + 13'sd189 - 13'(lzs);
      s4_sgn_r  <= s3_sgn_r;
      s4_zero_r <= (s3_sum_r == 63'd0);
      s4_spec_r <= s3_spec_r;
      s4_sval_r <= s3_sval_r;
    end
  end

  // ---------------- stage 5: round and pack -------------------------------
  logic [12:0] rsh;
  logic [5:0]  sh6;
  logic [63:0] mm, q64;
  logic        gbit, stk, rnd;
  logic [31:0] expf, bits, res;

  always_comb begin
    rsh  = (s4_be_r < 13'sd1) ? 13'(13'sd40 - s4_be_r) : 13'd39;
    sh6  = rsh[5:0];
    mm   = {1'b0, s4_m_r};
    q64  = 64'd0;
    gbit = 1'b0;
    stk  = 1'b0;
    if (rsh < 13'd64) begin
      q64  = mm >> sh6;
      gbit = mm[sh6 - 6'd1];
      stk  = |(mm & ((64'h1 << (sh6 - 6'd1)) - 64'h1));
    end
    rnd  = gbit && (stk || q64[0]);
    expf = (s4_be_r < 13'sd1) ? 32'd0 : 32'(s4_be_r - 13'sd1);
    bits = (expf << 23) + q64[31:0] + {31'd0, rnd};
    if (bits >= fexp_pkg::POS_INF || s4_be_r >= 13'sd255) begin
      bits = fexp_pkg::POS_INF;
    end
    priority if (s4_spec_r) begin
      res = s4_sval_r;
    end else if (s4_zero_r) begin
      res = 32'd0;
    end else begin
      res = {s4_sgn_r, bits[30:0]};
    end
  end

  logic [31:0] y_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      y_r <= res;
    end
  end

  assign y = y_r;

endmodule

`default_nettype wire

// ===== rtl/float32_exp_table_poly.sv =====
// ----------------------------------------------------------------------------
// float32_exp_table_poly
// Single-precision exp(x): magic-bias rounding, 64-entry 2^(i/64) table,
// two-step Cody-Waite reduction and degree-2 polynomial, eight chained FMAs.
//
//   channel | ports                          | beat
//   input   | in_valid, in_stall, in_data    | x_bits, is_last
//   output  | out_valid, out_stall, out_data | y_bits, last_out
//
// One beat per cycle sustained while the output is not stalled. The path is
// eight dependent five-stage FMA units in series plus an output register.
// Reset (rst_n low, synchronous) clears the valid bits; payload is not reset.
// The whole pipeline holds while out_valid is high and out_stall is high;
// in_stall follows that hold.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module float32_exp_table_poly (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fexp_pkg::exp_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fexp_pkg::exp_out_t out_data
);

  localparam int L     = fexp_pkg::FMA_LAT;
  localparam int NSTG  = 8 * L;
  localparam int LSN_D = 6 * L;

  logic ce;
  logic out_valid_r;

  assign ce       = !out_valid_r || !out_stall;
  assign in_stall = !ce;

  // valid bits and input beat, one entry per pipeline position; shorter delay lines for side values
  logic [NSTG-1:0]     vld_r;
  fexp_pkg::exp_in_t   x_line_r [NSTG];
  logic [31:0]         l_line_r [LSN_D];
  logic [31:0]         sn_line_r [LSN_D];
  logic [31:0]         n_line_r [L];
  logic [31:0]         t_line_r [L];

  logic [31:0] vn, n, t1, t2, p1, p2, f1, f2;

  fexp_fma u_fma_vn (.clk, .ce, .a(in_data.x_bits), .b(fexp_pkg::LOG2E_X64),
                     .c(fexp_pkg::MAGIC_BIAS), .y(vn));
  fexp_fma u_fma_n  (.clk, .ce, .a(vn), .b(fexp_pkg::ONE_F),
                     .c(fexp_pkg::NEG_MAGIC), .y(n));
  fexp_fma u_fma_t1 (.clk, .ce, .a(n), .b(fexp_pkg::NEG_LN2_HI),
                     .c(x_line_r[2*L-1].x_bits), .y(t1));
  fexp_fma u_fma_t2 (.clk, .ce, .a(n_line_r[L-1]), .b(fexp_pkg::LN2_LO),
                     .c(t1), .y(t2));
  fexp_fma u_fma_p1 (.clk, .ce, .a(t2), .b(fexp_pkg::COEF_C2),
                     .c(fexp_pkg::NEG_ZERO), .y(p1));
  fexp_fma u_fma_p2 (.clk, .ce, .a(t_line_r[L-1]), .b(p1),
                     .c(t_line_r[L-1]), .y(p2));
  fexp_fma u_fma_f1 (.clk, .ce, .a(l_line_r[5*L-1]), .b(p2),
                     .c(l_line_r[5*L-1]), .y(f1));
  fexp_fma u_fma_f2 (.clk, .ce, .a(f1), .b(sn_line_r[6*L-1]),
                     .c(fexp_pkg::NEG_ZERO), .y(f2));

  // scale split and table word from vn
  logic [31:0] eo, en, sn_nxt, l_nxt;

  always_comb begin
    eo = {vn[14:6], 23'd0};
    en = ($signed(eo) > $signed(fexp_pkg::MIN_EXPO)) ? eo : fexp_pkg::MIN_EXPO;
    en = ($signed(en) > $signed(fexp_pkg::MAX_EXPO)) ? fexp_pkg::MAX_EXPO : en;
    sn_nxt = en + fexp_pkg::MAX_EXPO;
    l_nxt  = fexp_pkg::POW2_FRAC[vn[5:0]] + (eo - en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x_line_r[0]  <= in_data;
      l_line_r[0]  <= l_nxt;
      sn_line_r[0] <= sn_nxt;
      n_line_r[0]  <= n;
      t_line_r[0]  <= t2;
      for (int i = 1; i < NSTG; i++) begin
        x_line_r[i] <= x_line_r[i-1];
      end
      for (int i = 1; i < LSN_D; i++) begin
        l_line_r[i]  <= l_line_r[i-1];
        sn_line_r[i] <= sn_line_r[i-1];
      end
      for (int i = 1; i < L; i++) begin
        n_line_r[i] <= n_line_r[i-1];
        t_line_r[i] <= t_line_r[i-1];
      end
    end
  end

  // cutoffs and NaN pass-through
  logic [31:0] xf, y_nxt;

  always_comb begin
    xf = x_line_r[NSTG-1].x_bits;
    priority if (xf[30:0] > fexp_pkg::POS_INF[30:0]) begin
      y_nxt = xf | fexp_pkg::QUIET_BIT;
    end else if (xf[31] && xf[30:0] > fexp_pkg::ZERO_CUTOFF[30:0]) begin
      y_nxt = 32'd0;
    end else if (!xf[31] && xf > fexp_pkg::INF_CUTOFF) begin
      y_nxt = fexp_pkg::POS_INF;
    end else begin
      y_nxt = f2;
    end
  end

  fexp_pkg::exp_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_data_r.y_bits   <= y_nxt;
      out_data_r.last_out <= x_line_r[NSTG-1].is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SVA_IMPL(a_stall_back, out_valid_r && out_stall, in_stall, "output hold not seen at input")
  `SVA_NEXT(a_pipe_hold, in_stall, $stable(vld_r), "valid bits moved during hold")
  `SVA_NEXT(a_beat_enter, in_valid && !in_stall, vld_r[0], "accepted beat not in pipeline")

endmodule

`default_nettype wire

// ===== dv/tb_float32_exp_table_poly.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_float32_exp_table_poly
// Feeds binary32 values through the exp pipeline with random gaps on the
// input side and random stalls on the result side. A local model computes
// every expected result from the arithmetic: fused multiply-adds that round
// once, table lookup and exponent clamping. Each result beat is checked
// against the oldest expected beat.
// ----------------------------------------------------------------------------
module tb_float32_exp_table_poly;

  localparam int NUM_EDGE = 24;

  localparam logic [31:0] EDGE_VALS [NUM_EDGE] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
    32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
    32'hFFFF_FFFF, 32'hFFC0_0001, fexp_pkg::ZERO_CUTOFF, fexp_pkg::ZERO_CUTOFF + 32'd1,
    fexp_pkg::INF_CUTOFF, fexp_pkg::INF_CUTOFF + 32'd1, 32'h0000_0001, 32'h8000_0001,
    32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h42B0_0000, 32'hC2AF_0000,
    32'hC2C8_0000, 32'hC2CF_F000, 32'h3380_0000, 32'h3F31_7218};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  fexp_pkg::exp_in_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  fexp_pkg::exp_out_t out_data;

  float32_exp_table_poly dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #4 clk = ~clk;

  fexp_pkg::exp_in_t  pending_q[$];
  fexp_pkg::exp_out_t exp_result_q[$];
  int       errors = 0;
  int       sent = 0;
  int       pause_at = 400;
  int       gap = 0;
  int       stall_cnt = 0;

  function automatic int msb_pos(logic [63:0] v);
    int p;
    p = 0;
    while (v > 64'd1) begin
      v = v >> 1;
      p++;
    end
    return p;
  endfunction

  function automatic logic [63:0] shift_sticky(logic [63:0] v, int d);
    logic [63:0] m;
    if (d <= 0) return v;
    if (d >= 63) return (v != 0) ? 64'd1 : 64'd0;
    m = (64'd1 << d) - 64'd1;
    return (v >> d) | (((v & m) != 0) ? 64'd1 : 64'd0);
  endfunction

  function automatic logic [31:0] round_to_f32(logic sgn, logic [63:0] mag, int e);
    int p, be, r;
    logic [63:0] q, rem, half;
    logic [31:0] bits;
    if (mag == 0) return 32'd0;
    p = msb_pos(mag);
    be = p + e + 127;
    if (be >= 255) return {sgn, fexp_pkg::POS_INF[30:0]};
    r = p - 23;
    if (be < 1) r += 1 - be;
    if (r <= 0) begin
      q = mag << (-r);
    end else if (r >= 64) begin
      q = 0;
    end else begin
      rem = mag & ((64'd1 << r) - 64'd1);
      half = 64'd1 << (r - 1);
      q = mag >> r;
      if (rem > half || (rem == half && q[0])) q++;
    end
    bits = (32'(be < 1 ? 0 : be - 1) << 23) + q[31:0];
    if (bits >= fexp_pkg::POS_INF) bits = fexp_pkg::POS_INF;
    return {sgn, 31'b0} | bits;
  endfunction

  function automatic logic [31:0] fused_mul_add(logic [31:0] a, logic [31:0] b,
                                                logic [31:0] c);
    logic sp, sc, sg;
    logic [7:0] ea, eb, ec;
    logic [22:0] fa, fb, fc;
    logic [63:0] mp, mc, sum;
    int ep, ecx, sh;
    sp = a[31] ^ b[31];
    sc = c[31];
    ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
    fa = a[22:0]; fb = b[22:0]; fc = c[22:0];
    if ((ea == 8'hFF && fa != 0) || (eb == 8'hFF && fb != 0) || (ec == 8'hFF && fc != 0))
      return fexp_pkg::QNAN_F;
    if (ea == 8'hFF || eb == 8'hFF) begin
      if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0)) return fexp_pkg::QNAN_F;
      if (ec == 8'hFF && sc != sp) return fexp_pkg::QNAN_F;
      return {sp, fexp_pkg::POS_INF[30:0]};
    end
    if (ec == 8'hFF) return c;
    mp = 64'({ea != 0, fa}) * 64'({eb != 0, fb});
    ep = int'(ea != 0 ? ea : 8'd1) + int'(eb != 0 ? eb : 8'd1) - 300;
    mc = 64'({ec != 0, fc});
    ecx = int'(ec != 0 ? ec : 8'd1) - 150;
    if (mp == 0 && mc == 0) return (sp && sc) ? fexp_pkg::NEG_ZERO : 32'd0;
    if (mp == 0) return c;
    sh = 61 - msb_pos(mp);
    mp = mp << sh;
    ep -= sh;
    if (mc == 0) return round_to_f32(sp, mp, ep);
    sh = 61 - msb_pos(mc);
    mc = mc << sh;
    ecx -= sh;
    if (ep >= ecx) begin
      mc = shift_sticky(mc, ep - ecx);
    end else begin
      mp = shift_sticky(mp, ecx - ep);
      ep = ecx;
    end
    if (sp == sc) begin
      sum = mp + mc; sg = sp;
    end else if (mp >= mc) begin
      sum = mp - mc; sg = sp;
    end else begin
      sum = mc - mp; sg = sc;
    end
    if (sum == 0) return 32'd0;
    return round_to_f32(sg, sum, ep);
  endfunction

  function automatic logic signed_gt(logic [31:0] a, logic [31:0] b);
    return (a ^ 32'h8000_0000) > (b ^ 32'h8000_0000);
  endfunction

  function automatic fexp_pkg::exp_out_t exp_of(fexp_pkg::exp_in_t item);
    logic [31:0] x, vn, eo, en, sn, l, n, t, p, f;
    fexp_pkg::exp_out_t res;
    x = item.x_bits;
    if ((x & 32'h7FFF_FFFF) > fexp_pkg::POS_INF) begin
      f = x | fexp_pkg::QUIET_BIT;
    end else begin
      vn = fused_mul_add(x, fexp_pkg::LOG2E_X64, fexp_pkg::MAGIC_BIAS);
      eo = (vn & 32'hFFFF_FFC0) << 17;
      en = signed_gt(eo, fexp_pkg::MIN_EXPO) ? eo : fexp_pkg::MIN_EXPO;
      en = signed_gt(en, fexp_pkg::MAX_EXPO) ? fexp_pkg::MAX_EXPO : en;
      eo = eo - en;
      sn = en + fexp_pkg::MAX_EXPO;
      l = fexp_pkg::POW2_FRAC[vn[5:0]] + eo;
      n = fused_mul_add(vn, fexp_pkg::ONE_F, fexp_pkg::NEG_MAGIC);
      t = fused_mul_add(n, fexp_pkg::NEG_LN2_HI, x);
      t = fused_mul_add(n, fexp_pkg::LN2_LO, t);
      p = fused_mul_add(t, fexp_pkg::COEF_C2, fexp_pkg::NEG_ZERO);
      p = fused_mul_add(t, p, t);
      f = fused_mul_add(l, p, l);
      f = fused_mul_add(f, sn, fexp_pkg::NEG_ZERO);
      if (x[31] && (x & 32'h7FFF_FFFF) > (fexp_pkg::ZERO_CUTOFF & 32'h7FFF_FFFF))
        f = 32'd0;
      if (!x[31] && x > fexp_pkg::INF_CUTOFF) f = fexp_pkg::POS_INF;
    end
    res.y_bits = f;
    res.last_out = item.is_last;
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    logic busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        exp_result_q.push_back(exp_of(in_data));
        sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0 &&
                     !(sent == pause_at && exp_result_q.size() > 0)) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
          gap = (sent >= 800 && sent < 1000) ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    fexp_pkg::exp_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_result_q.size() == 0) begin
          $error("unexpected result beat y_bits=%h", out_data.y_bits);
          errors++;
        end else begin
          want = exp_result_q.pop_front();
          if (out_data.y_bits !== want.y_bits) begin
            $error("y_bits expected %h actual %h", want.y_bits, out_data.y_bits);
            errors++;
          end
          if (out_data.last_out !== want.last_out) begin
            $error("last_out expected %b actual %b", want.last_out, out_data.last_out);
            errors++;
          end
        end
        stall_cnt = (sent >= 1200 && sent < 1400) ? 0 : $urandom_range(0, 3);
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic fexp_pkg::exp_in_t mk(logic [31:0] x);
    fexp_pkg::exp_in_t it;
    it.x_bits = x;
    it.is_last = 1'($urandom_range(0, 1));
    return it;
  endfunction

  initial begin
    logic [31:0] x;
    for (int i = 0; i < NUM_EDGE; i++) pending_q.push_back(mk(EDGE_VALS[i]));
    pending_q[0].is_last = 1'b0;
    pending_q[1].is_last = 1'b1;
    repeat (1600) begin
      case ($urandom_range(0, 9))
        0, 1, 2: x = $urandom;
        3: x = (($urandom_range(0, 1) != 0) ? fexp_pkg::ZERO_CUTOFF : fexp_pkg::INF_CUTOFF)
               + $urandom_range(0, 64) - 32;
        default: x = {1'($urandom_range(0, 1)), 8'($urandom_range(100, 133)),
                      23'($urandom)};
      endcase
      pending_q.push_back(mk(x));
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() > 0 || in_valid) @(posedge clk);
    while (exp_result_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && exp_result_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
